// ----- hw/rtl/hvte_pkg.sv -----
// Shared types and constants for the HTML visible-text extractor.
// Used by the front, queue, back and top-level modules; depends on nothing.
package hvte_pkg;

  localparam int WinSpan = 9;  // eight lookahead bytes plus the byte being decided

  localparam logic [3:0] WIN_DEPTH = 4'd8;
  localparam logic [3:0] WIN_FULL  = 4'd9;

  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [3:0] SKIP_CMT_OPEN  = 4'd3;
  localparam logic [3:0] SKIP_CMT_CLOSE = 4'd2;
  localparam logic [3:0] SKIP_SCR_OPEN  = 4'd6;
  localparam logic [3:0] SKIP_SCR_CLOSE = 4'd8;
  localparam logic [3:0] SKIP_STY_OPEN  = 4'd5;
  localparam logic [3:0] SKIP_STY_CLOSE = 4'd7;

  typedef logic [WinSpan-1:0][7:0] win_t;

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_TAG,
    MODE_COMMENT,
    MODE_SCRIPT,
    MODE_STYLE
  } mode_t;

  typedef enum logic [1:0] {
    SEP_NONE,
    SEP_SPACE,
    SEP_NEWLINE
  } sep_t;

  // Pattern flags for one decided byte; they depend on the window and its fill count only.
  typedef struct packed {
    logic       eod;
    logic [7:0] ch;
    logic       lt;
    logic       gt;
    logic       ws;
    logic       cmt_open;
    logic       cmt_close;
    logic       scr_open;
    logic       scr_close;
    logic       sty_open;
    logic       sty_close;
    logic       blk_close;
  } tok_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       end_of_text;
  } item_t;

  function automatic logic [7:0] to_lower(input logic [7:0] x);
    to_lower = (x >= "A" && x <= "Z") ? 8'(x + 8'd32) : x;
  endfunction

  function automatic logic is_ws(input logic [7:0] x);
    is_ws = x inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

endpackage

// ----- hw/rtl/hvte_front.sv -----
// Front end: holds the lookahead window, accepts input words and turns each
// decided byte into a token of pattern flags. Depends on hvte_pkg.
module hvte_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_html_byte,
  input  logic          in_last_byte,
  output logic          in_stall,
  input  logic          q_ready,
  output logic          push,
  output hvte_pkg::tok_t push_tok
);
  import hvte_pkg::*;

  win_t       win_r, win_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       drain_r, drain_nxt;
  win_t       view;
  logic       accept;

  function automatic win_t shift_win(input win_t w);
    win_t s;
    s = w;
    for (int i = 0; i < WinSpan - 1; i++) begin
      s[i] = w[i+1];
    end
    shift_win = s;
  endfunction

  function automatic tok_t classify(input win_t b, input logic [3:0] avail);
    tok_t t;
    logic scr_word1, sty_word1, scr_word2, sty_word2;
    logic [7:0] n1;
    scr_word1 = to_lower(b[1]) == "s" && to_lower(b[2]) == "c" && to_lower(b[3]) == "r" &&
                to_lower(b[4]) == "i" && to_lower(b[5]) == "p" && to_lower(b[6]) == "t";
    sty_word1 = to_lower(b[1]) == "s" && to_lower(b[2]) == "t" && to_lower(b[3]) == "y" &&
                to_lower(b[4]) == "l" && to_lower(b[5]) == "e";
    scr_word2 = to_lower(b[2]) == "s" && to_lower(b[3]) == "c" && to_lower(b[4]) == "r" &&
                to_lower(b[5]) == "i" && to_lower(b[6]) == "p" && to_lower(b[7]) == "t";
    sty_word2 = to_lower(b[2]) == "s" && to_lower(b[3]) == "t" && to_lower(b[4]) == "y" &&
                to_lower(b[5]) == "l" && to_lower(b[6]) == "e";
    n1 = to_lower(b[2]);
    t = '0;
    t.ch = b[0];
    t.lt = b[0] == CH_LT;
    t.gt = b[0] == CH_GT;
    t.ws = is_ws(b[0]);
    t.cmt_close = b[0] == CH_DASH && avail > 4'd2 && b[1] == CH_DASH && b[2] == CH_GT;
    t.scr_close = t.lt && avail > 4'd8 && b[1] == CH_SLASH && scr_word2 && b[8] == CH_GT;
    t.sty_close = t.lt && avail > 4'd7 && b[1] == CH_SLASH && sty_word2 && b[7] == CH_GT;
    t.cmt_open  = avail > 4'd3 && b[1] == CH_BANG && b[2] == CH_DASH && b[3] == CH_DASH;
    t.scr_open  = avail > 4'd7 && scr_word1 && (b[7] == CH_GT || is_ws(b[7]));
    t.sty_open  = avail > 4'd6 && sty_word1 && (b[6] == CH_GT || is_ws(b[6]));
    if (avail > 4'd2 && b[1] == CH_SLASH) begin
      case (n1)
        "p":     t.blk_close = avail > 4'd3 && b[3] == CH_GT;
        "d":     t.blk_close = avail > 4'd5 && to_lower(b[3]) == "i" &&
                               to_lower(b[4]) == "v" && b[5] == CH_GT;
        "l":     t.blk_close = avail > 4'd4 && to_lower(b[3]) == "i" && b[4] == CH_GT;
        "b":     t.blk_close = avail > 4'd4 && to_lower(b[3]) == "r" && b[4] == CH_GT;
        "h":     t.blk_close = avail > 4'd4 && b[3] >= CH_ONE && b[3] <= CH_SIX &&
                               b[4] == CH_GT;
        default: t.blk_close = 1'b0;
      endcase
    end
    classify = t;
  endfunction

  // While the window drains after the last word, no new word is taken.
  assign in_stall = drain_r || !q_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    view = win_r;
    for (int i = 0; i < WinSpan; i++) begin
      if (4'(i) == cnt_r) view[i] = in_html_byte;
    end
  end

  always_comb begin
    win_nxt   = win_r;
    cnt_nxt   = cnt_r;
    drain_nxt = drain_r;
    push      = 1'b0;
    push_tok  = '0;
    if (drain_r) begin
      if (q_ready) begin
        push = 1'b1;
        if (cnt_r != 4'd0) begin
          push_tok = classify(win_r, cnt_r);
          win_nxt  = shift_win(win_r);
          cnt_nxt  = cnt_r - 4'd1;
        end else begin
          push_tok.eod = 1'b1;
          drain_nxt    = 1'b0;
        end
      end
    end else if (accept) begin
      if (in_last_byte) begin
        win_nxt   = view;
        cnt_nxt   = cnt_r + 4'd1;
        drain_nxt = 1'b1;
      end else if (cnt_r == WIN_DEPTH) begin
        push     = 1'b1;
        push_tok = classify(view, WIN_FULL);
        win_nxt  = shift_win(view);
      end else begin
        win_nxt = view;
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (!rst_n) begin
      cnt_r   <= '0;
      drain_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// ----- hw/rtl/hvte_queue.sv -----
// Short token queue between the front end and the back end.
// Depends on hvte_pkg for the token type and depth constants.
module hvte_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hvte_pkg::tok_t push_tok,
  output logic           q_ready,
  output logic           q_valid,
  output hvte_pkg::tok_t q_tok,
  input  logic           pop
);
  import hvte_pkg::*;

  tok_t             ent_r [QDepth];
  logic [QPtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_ready = cnt_r != QCntW'(QDepth);
  assign q_valid = cnt_r != '0;
  assign q_tok   = ent_r[rd_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_r] <= push_tok;
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/hvte_back.sv -----
// Back end: applies the parse state machine to each token and drives the
// registered result channel, holding a second word behind a separator.
// Depends on hvte_pkg.
module hvte_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  hvte_pkg::tok_t q_tok,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_text_byte,
  output logic           out_byte_valid,
  output logic           out_end_of_text
);
  import hvte_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [3:0] skip_r, skip_nxt;
  sep_t       pend_r, pend_nxt;
  logic       started_r, started_nxt;
  item_t      out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       hold_v_r, hold_v_nxt;

  logic  emit_char, emit_sep, emits, out_free;
  item_t first_item;

  // Output decode for the token at the head of the queue.
  always_comb begin
    emit_char  = !q_tok.eod && skip_r == 4'd0 && mode_r == MODE_TEXT &&
                 !q_tok.lt && !q_tok.ws;
    emit_sep   = emit_char && pend_r != SEP_NONE;
    emits      = emit_char || q_tok.eod;
    first_item = '0;
    if (emit_sep) begin
      first_item.text_byte  = (pend_r == SEP_NEWLINE) ? CH_LF : CH_SPACE;
      first_item.byte_valid = 1'b1;
    end else if (emit_char) begin
      first_item.text_byte  = q_tok.ch;
      first_item.byte_valid = 1'b1;
    end else begin
      first_item.end_of_text = 1'b1;
    end
  end

  // Next parse state for a token that is taken from the queue.
  always_comb begin
    mode_nxt    = mode_r;
    skip_nxt    = skip_r;
    pend_nxt    = pend_r;
    started_nxt = started_r;
    if (pop) begin
      if (q_tok.eod) begin
        mode_nxt    = MODE_TEXT;
        skip_nxt    = '0;
        pend_nxt    = SEP_NONE;
        started_nxt = 1'b0;
      end else if (skip_r != 4'd0) begin
        skip_nxt = skip_r - 4'd1;
      end else begin
        case (mode_r)
          MODE_COMMENT: begin
            if (q_tok.cmt_close) begin
              mode_nxt = MODE_TEXT;
              skip_nxt = SKIP_CMT_CLOSE;
            end
          end
          MODE_SCRIPT: begin
            if (q_tok.scr_close) begin
              mode_nxt = MODE_TEXT;
              skip_nxt = SKIP_SCR_CLOSE;
            end
          end
          MODE_STYLE: begin
            if (q_tok.sty_close) begin
              mode_nxt = MODE_TEXT;
              skip_nxt = SKIP_STY_CLOSE;
            end
          end
          MODE_TEXT, MODE_TAG: begin
            if (q_tok.lt) begin
              if (q_tok.cmt_open) begin
                mode_nxt = MODE_COMMENT;
                skip_nxt = SKIP_CMT_OPEN;
              end else if (q_tok.scr_open) begin
                mode_nxt = MODE_SCRIPT;
                skip_nxt = SKIP_SCR_OPEN;
              end else if (q_tok.sty_open) begin
                mode_nxt = MODE_STYLE;
                skip_nxt = SKIP_STY_OPEN;
              end else begin
                mode_nxt = MODE_TAG;
                if (q_tok.blk_close && started_r) pend_nxt = SEP_NEWLINE;
              end
            end else if (mode_r == MODE_TAG) begin
              if (q_tok.gt) mode_nxt = MODE_TEXT;
            end else if (q_tok.ws) begin
              if (started_r && pend_r == SEP_NONE) pend_nxt = SEP_SPACE;
            end else begin
              pend_nxt    = SEP_NONE;
              started_nxt = 1'b1;
            end
          end
          default: mode_nxt = MODE_TEXT;
        endcase
      end
    end
  end

  // A token that emits nothing may pass even while the output is stalled.
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = q_valid && !hold_v_r && (out_free || !emits);

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    hold_nxt      = hold_r;
    hold_v_nxt    = hold_v_r;
    if (out_free) begin
      out_valid_nxt = 1'b0;
      if (hold_v_r) begin
        out_nxt       = '{text_byte: hold_r, byte_valid: 1'b1, end_of_text: 1'b0};
        out_valid_nxt = 1'b1;
        hold_v_nxt    = 1'b0;
      end else if (pop && emits) begin
        out_nxt       = first_item;
        out_valid_nxt = 1'b1;
        if (emit_sep) begin
          hold_nxt   = q_tok.ch;
          hold_v_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
    if (!rst_n) begin
      mode_r      <= MODE_TEXT;
      skip_r      <= '0;
      pend_r      <= SEP_NONE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      hold_v_r    <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      skip_r      <= skip_nxt;
      pend_r      <= pend_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      hold_v_r    <= hold_v_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_text_byte   = out_r.text_byte;
  assign out_byte_valid  = out_r.byte_valid;
  assign out_end_of_text = out_r.end_of_text;

endmodule

// ----- hw/rtl/html_visible_text_extractor_core.sv -----
// A byte is decided once eight later bytes have arrived (or at the last byte);
// its token passes through the token queue and then into the registered result word.
// Throughput: one input word per cycle while in_stall is low; a word that needs a separator
// before it is held back while the separator word goes out first. The last word starts a
// drain (one token per held byte plus the end word) during which in_stall is high.
// Reset: synchronous, active-low rst_n clears the window fill count, queue and parse state.
module html_visible_text_extractor_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_html_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_text_byte,
  output logic       out_byte_valid,
  output logic       out_end_of_text
);
  import hvte_pkg::*;

  logic push, q_ready, q_valid, pop;
  tok_t push_tok, q_tok;

  hvte_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_html_byte (in_html_byte),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .q_ready      (q_ready),
    .push         (push),
    .push_tok     (push_tok)
  );

  hvte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_tok    (q_tok),
    .pop      (pop)
  );

  hvte_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_tok           (q_tok),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_text_byte   (out_text_byte),
    .out_byte_valid  (out_byte_valid),
    .out_end_of_text (out_end_of_text)
  );

endmodule

// ----- hw/rtl/hvte_checker.sv -----
// Port-level checks for the HTML visible-text extractor, bound to the top level.
// Depends only on the top level's ports.
module hvte_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_html_byte,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_text_byte,
  input logic       out_byte_valid,
  input logic       out_end_of_text
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable({out_text_byte, out_byte_valid, out_end_of_text}))
    else $error("result word changed while stalled");

  // The end word carries no character.
  a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_text |-> !out_byte_valid && out_text_byte == 8'h00)
    else $error("end word carries a character");

  // Every other word carries a character.
  a_text_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_text |-> out_byte_valid)
    else $error("text word without a character");

  // The window drains after the last word, so input is held off next cycle.
  a_drain_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_byte |=> in_stall)
    else $error("input taken during drain");

endmodule

bind html_visible_text_extractor_core hvte_checker u_hvte_checker (.*);
